// ===== src/mips_subset_execute_defines.svh =====
// Assertion helpers shared by the execute block.
`ifndef MIPS_SUBSET_EXECUTE_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MSE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

    localparam int unsigned XLEN        = 32;
    localparam int unsigned REG_COUNT   = 32;
    localparam int unsigned RF_AW       = $clog2(REG_COUNT);
    // Word count of the data memory; a power of two, so the index wraps by masking.
    localparam int unsigned DATA_WORDS  = 2048;
    localparam int unsigned DMEM_AW     = $clog2(DATA_WORDS);
    localparam int unsigned MEM_INDEX_W = 11;
    localparam int unsigned IMM_W       = 16;
    localparam logic [XLEN-1:0] PC_STEP = 32'd4;

    typedef logic [XLEN-1:0]        word_t;
    typedef logic [RF_AW-1:0]       reg_idx_t;
    typedef logic [DMEM_AW-1:0]     dmem_idx_t;
    typedef logic [IMM_W-1:0]       imm_t;
    typedef logic [MEM_INDEX_W-1:0] mem_index_t;

    typedef enum logic [2:0] {
        KIND_ADD    = 3'd0,
        KIND_SUB    = 3'd1,
        KIND_ADDI   = 3'd2,
        KIND_MUL    = 3'd3,
        KIND_LW     = 3'd4,
        KIND_SW     = 3'd5,
        KIND_BEQ    = 3'd6,
        KIND_BUBBLE = 3'd7
    } kind_t;

    // Register file write port
    typedef struct packed {
        logic     en;
        reg_idx_t idx;
        word_t    data;
    } rf_wr_t;

    // Data memory access from the execute stage
    typedef struct packed {
        logic      rd_en;
        logic      wr_en;
        dmem_idx_t idx;
        word_t     data;
    } dmem_req_t;

    // One finished result
    typedef struct packed {
        word_t      next_pc;
        logic       branch_taken;
        logic       reg_write;
        reg_idx_t   reg_index;
        word_t      reg_value;
        logic       mem_write;
        mem_index_t mem_index;
        word_t      mem_value;
    } res_t;

    function automatic mem_index_t to_mem_index(input dmem_idx_t idx);
        logic [XLEN-1:0] wide;
        wide = XLEN'(idx);
        return wide[MEM_INDEX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/mse_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mse_in_if;
    import mse_pkg::*;

    logic     valid;
    logic     ready;
    kind_t    kind;
    reg_idx_t src_reg;
    reg_idx_t second_reg;
    reg_idx_t dest_reg;
    imm_t     imm_value;

    modport source (
        output valid, kind, src_reg, second_reg, dest_reg, imm_value,
        input  ready
    );
    modport sink (
        input  valid, kind, src_reg, second_reg, dest_reg, imm_value,
        output ready
    );
endinterface

interface mse_out_if;
    import mse_pkg::*;

    logic               valid;
    logic               ready;
    word_t              next_pc;
    logic               branch_taken;
    logic               reg_write;
    reg_idx_t           reg_index;
    logic signed [31:0] reg_value;
    logic               mem_write;
    mem_index_t         mem_index;
    logic signed [31:0] mem_value;

    modport source (
        output valid, next_pc, branch_taken, reg_write, reg_index, reg_value,
               mem_write, mem_index, mem_value,
        input  ready
    );
    modport sink (
        input  valid, next_pc, branch_taken, reg_write, reg_index, reg_value,
               mem_write, mem_index, mem_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/mse_regfile.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mse_regfile (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           rd_en,
    input  wire mse_pkg::reg_idx_t rd_addr_a,
    input  wire mse_pkg::reg_idx_t rd_addr_b,
    output mse_pkg::word_t      rd_data_a,
    output mse_pkg::word_t      rd_data_b,
    input  wire mse_pkg::rf_wr_t wr
);
    import mse_pkg::*;

    word_t                rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] written_reg;
    word_t                rdata_a_reg;
    word_t                rdata_b_reg;
    logic                 hit_a_reg;
    logic                 hit_b_reg;

    // 2R1W, read-before-write; entries not yet written read as zero
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            rf_mem[wr.idx] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_a_reg <= rf_mem[rd_addr_a];
            rdata_b_reg <= rf_mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hit_a_reg   <= 1'b0;
            hit_b_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                written_reg[wr.idx] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_a_reg <= written_reg[rd_addr_a];
                hit_b_reg <= written_reg[rd_addr_b];
            end
        end
    end

    assign rd_data_a = hit_a_reg ? rdata_a_reg : '0;
    assign rd_data_b = hit_b_reg ? rdata_b_reg : '0;

endmodule

`default_nettype wire

// ===== src/mse_dmem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mse_dmem (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mse_pkg::dmem_req_t req,
    output mse_pkg::word_t         rd_data,
    output logic                   busy
);
    import mse_pkg::*;

    word_t     dmem [DATA_WORDS];
    word_t     rdata_reg;
    logic      clr_busy_reg;
    dmem_idx_t clr_idx_reg;
    logic      wr_en;
    dmem_idx_t wr_idx;
    word_t     wr_data;

    // Zeroing sweep after reset takes the single write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= dmem_idx_t'(clr_idx_reg + 1'b1);
            if (clr_idx_reg == dmem_idx_t'(DATA_WORDS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        wr_en   = clr_busy_reg || req.wr_en;
        wr_idx  = clr_busy_reg ? clr_idx_reg : req.idx;
        wr_data = clr_busy_reg ? '0 : req.data;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dmem[wr_idx] <= wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= dmem[req.idx];
        end
    end

    assign rd_data = rdata_reg;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

// ===== src/mips_subset_execute.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Executes one decoded instruction (add, sub, addi, mul, lw, sw, beq, bubble)
// per transfer and returns one result per instruction, in order. Sustained
// rate is one instruction per clock while results are taken and no sweep
// runs; a result passes the read stage, execute stage and output register,
// and is held there until taken, while earlier stages keep filling.
// Both the register file (two read ports, one write port) and the data
// memory (one read port, one write port) are read synchronously.
// After reset the data memory is swept to zero, one word per cycle, through
// all DATA_WORDS (2048) words; instr.ready stays low until the sweep is done.
// Register 0 always reads as zero and writes to it are dropped.
module mips_subset_execute (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mse_in_if.sink     instr,
    mse_out_if.source  result
);
    import mse_pkg::*;

    `include "mips_subset_execute_defines.svh"

    // ---------------- handshake / stage control ----------------
    logic in_xfer;
    logic s1_adv;
    logic s2_adv;
    logic s1_ready;
    logic s2_ready;
    logic out_free;
    logic dmem_busy;

    // ---------------- read stage (s1) ----------------
    logic      s1_valid_reg;
    kind_t     s1_kind_reg;
    reg_idx_t  s1_rs_reg;
    reg_idx_t  s1_rt_reg;
    reg_idx_t  s1_rd_reg;
    imm_t      s1_imm_reg;

    word_t     rf_data_a;
    word_t     rf_data_b;
    word_t     op_a;
    word_t     op_b;
    word_t     sum_ai;
    word_t     pc_plus4;
    word_t     br_target;

    word_t     ex_next_pc;
    logic      ex_taken;
    logic      ex_wr_raw;
    logic      ex_wr;
    reg_idx_t  ex_widx;
    word_t     ex_alu;
    logic      ex_mrd;
    logic      ex_mwr;
    dmem_idx_t ex_midx;
    word_t     ex_mval;
    word_t     ex_prod;

    word_t     pc_reg;

    // ---------------- execute stage (s2) ----------------
    logic      s2_valid_reg;
    kind_t     s2_kind_reg;
    word_t     s2_next_pc_reg;
    logic      s2_taken_reg;
    logic      s2_wr_reg;
    reg_idx_t  s2_widx_reg;
    word_t     s2_alu_reg;
    word_t     s2_prod_reg;
    logic      s2_mwr_reg;
    dmem_idx_t s2_midx_reg;
    word_t     s2_mval_reg;
    word_t     s2_wval;

    // ---------------- write-back / output ----------------
    rf_wr_t    rf_wr;
    rf_wr_t    last_wr_reg;
    dmem_req_t dmem_req;
    word_t     dmem_rdata;
    logic      out_valid_reg;
    res_t      out_res_reg;
    res_t      res_next;

    // Each stage frees up when the one ahead moves or is empty
    assign out_free    = !out_valid_reg || result.ready;
    assign s2_ready    = !s2_valid_reg || out_free;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign s2_adv      = s2_valid_reg && out_free;
    assign s1_adv      = s1_valid_reg && s2_ready;
    assign instr.ready = s1_ready && !dmem_busy;
    assign in_xfer     = instr.valid && instr.ready;

    // Register file: operands read at the input transfer, committed at s2 exit
    mse_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_xfer),
        .rd_addr_a (instr.src_reg),
        .rd_addr_b (instr.second_reg),
        .rd_data_a (rf_data_a),
        .rd_data_b (rf_data_b),
        .wr        (rf_wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_kind_reg <= instr.kind;
            s1_rs_reg   <= instr.src_reg;
            s1_rt_reg   <= instr.second_reg;
            s1_rd_reg   <= instr.dest_reg;
            s1_imm_reg  <= instr.imm_value;
        end
    end

    // Bypass: the instruction in s2 (not yet written) first, then the most
    // recent commit, which the RAM read may have missed.
    always_comb
    begin
        op_a = rf_data_a;
        if (s2_valid_reg && s2_wr_reg && s2_widx_reg == s1_rs_reg)
        begin
            op_a = s2_wval;
        end
        else if (last_wr_reg.en && last_wr_reg.idx == s1_rs_reg)
        begin
            op_a = last_wr_reg.data;
        end

        op_b = rf_data_b;
        if (s2_valid_reg && s2_wr_reg && s2_widx_reg == s1_rt_reg)
        begin
            op_b = s2_wval;
        end
        else if (last_wr_reg.en && last_wr_reg.idx == s1_rt_reg)
        begin
            op_b = last_wr_reg.data;
        end
    end

    // Execute decode
    always_comb
    begin
        sum_ai    = op_a + XLEN'(s1_imm_reg);
        pc_plus4  = pc_reg + PC_STEP;
        br_target = pc_plus4 + (XLEN'(s1_imm_reg) << 2);
        ex_prod   = op_a * op_b;

        ex_next_pc = pc_plus4;
        ex_taken   = 1'b0;
        ex_wr_raw  = 1'b0;
        ex_widx    = '0;
        ex_alu     = '0;
        ex_mrd     = 1'b0;
        ex_mwr     = 1'b0;
        ex_midx    = '0;
        ex_mval    = '0;

        unique case (s1_kind_reg)
            KIND_ADD:
            begin
                ex_wr_raw = 1'b1;
                ex_widx   = s1_rd_reg;
                ex_alu    = op_a + op_b;
            end
            KIND_SUB:
            begin
                ex_wr_raw = 1'b1;
                ex_widx   = s1_rd_reg;
                ex_alu    = op_a - op_b;
            end
            KIND_ADDI:
            begin
                ex_wr_raw = 1'b1;
                ex_widx   = s1_rt_reg;
                ex_alu    = sum_ai;
            end
            KIND_MUL:
            begin
                ex_wr_raw = 1'b1;
                ex_widx   = s1_rd_reg;
            end
            KIND_LW:
            begin
                ex_wr_raw = 1'b1;
                ex_widx   = s1_rt_reg;
                ex_mrd    = 1'b1;
                ex_midx   = sum_ai[DMEM_AW-1:0];
            end
            KIND_SW:
            begin
                ex_mwr  = 1'b1;
                ex_midx = sum_ai[DMEM_AW-1:0];
                ex_mval = op_b;
            end
            KIND_BEQ:
            begin
                if (op_a == op_b)
                begin
                    ex_taken   = 1'b1;
                    ex_next_pc = br_target;
                end
            end
            KIND_BUBBLE:
            begin
                ex_next_pc = pc_reg;
            end
            default:
            begin
                ex_next_pc = pc_reg;
            end
        endcase

        // Writes to register 0 are dropped entirely
        ex_wr = ex_wr_raw && (ex_widx != '0);
        if (!ex_wr)
        begin
            ex_widx = '0;
            ex_alu  = '0;
        end
    end

    // Data memory: stores land in program order as they leave s1, so a
    // later load always reads the stored word from the array.
    always_comb
    begin
        dmem_req.rd_en = s1_adv && ex_mrd;
        dmem_req.wr_en = s1_adv && ex_mwr;
        dmem_req.idx   = ex_midx;
        dmem_req.data  = ex_mval;
    end

    mse_dmem u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (dmem_req),
        .rd_data (dmem_rdata),
        .busy    (dmem_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                pc_reg       <= ex_next_pc;
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_kind_reg    <= s1_kind_reg;
            s2_next_pc_reg <= ex_next_pc;
            s2_taken_reg   <= ex_taken;
            s2_wr_reg      <= ex_wr;
            s2_widx_reg    <= ex_widx;
            s2_alu_reg     <= ex_alu;
            s2_prod_reg    <= ex_prod;
            s2_mwr_reg     <= ex_mwr;
            s2_midx_reg    <= ex_midx;
            s2_mval_reg    <= ex_mval;
        end
    end

    // Write-back value: zero without a write, else product, loaded word or ALU result
    always_comb
    begin
        priority if (!s2_wr_reg)
        begin
            s2_wval = '0;
        end
        else if (s2_kind_reg == KIND_MUL)
        begin
            s2_wval = s2_prod_reg;
        end
        else if (s2_kind_reg == KIND_LW)
        begin
            s2_wval = dmem_rdata;
        end
        else
        begin
            s2_wval = s2_alu_reg;
        end
    end

    always_comb
    begin
        rf_wr.en   = s2_adv && s2_wr_reg;
        rf_wr.idx  = s2_widx_reg;
        rf_wr.data = s2_wval;

        res_next.next_pc      = s2_next_pc_reg;
        res_next.branch_taken = s2_taken_reg;
        res_next.reg_write    = s2_wr_reg;
        res_next.reg_index    = s2_widx_reg;
        res_next.reg_value    = s2_wval;
        res_next.mem_write    = s2_mwr_reg;
        res_next.mem_index    = to_mem_index(s2_midx_reg);
        res_next.mem_value    = s2_mval_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_wr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rf_wr.en)
            begin
                last_wr_reg <= rf_wr;
            end
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_res_reg <= res_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.next_pc      = out_res_reg.next_pc;
    assign result.branch_taken = out_res_reg.branch_taken;
    assign result.reg_write    = out_res_reg.reg_write;
    assign result.reg_index    = out_res_reg.reg_index;
    assign result.reg_value    = $signed(out_res_reg.reg_value);
    assign result.mem_write    = out_res_reg.mem_write;
    assign result.mem_index    = out_res_reg.mem_index;
    assign result.mem_value    = $signed(out_res_reg.mem_value);

    // ---------------- assertions ----------------
    `MSE_ASSERT_NOW(a_sweep_blocks_input, clk, rst_n, dmem_busy, !instr.ready, "input open during memory sweep")
    `MSE_ASSERT_NOW(a_no_r0_commit, clk, rst_n, rf_wr.en, rf_wr.idx != '0, "commit to register zero")
    `MSE_ASSERT_NEXT(a_bubble_holds_pc, clk, rst_n, s1_adv && s1_kind_reg == KIND_BUBBLE, pc_reg == $past(pc_reg), "bubble moved the pc")
    `MSE_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, s2_adv, result.valid && last_wr_reg.en == ($past(rf_wr.en) || $past(last_wr_reg.en)), "commit lost")

endmodule

`default_nettype wire

// ===== sim/mse_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, runs its own model of the datapath on each
// instruction transfer and compares every result transfer against it.
module mse_checker (
    input  logic clk,
    input  logic rst_n,
    mse_in_if    instr_mon,
    mse_out_if   result_mon,
    output int   failures,
    output int   outstanding,
    output int   results_checked
);
    import mse_pkg::*;

    word_t arch_regs [REG_COUNT];
    word_t data_mem  [DATA_WORDS];
    word_t arch_pc;
    res_t  results_due [$];
    int    fail_count = 0;
    int    check_count = 0;

    // Architectural effect of one instruction; updates the model state.
    function automatic res_t execute_instr(input kind_t k, input reg_idx_t rs,
                                           input reg_idx_t rt, input reg_idx_t rd,
                                           input imm_t imm);
        word_t     op_a;
        word_t     op_b;
        word_t     addr_sum;
        dmem_idx_t word_idx;
        res_t      r;
        op_a     = (rs == '0) ? '0 : arch_regs[rs];
        op_b     = (rt == '0) ? '0 : arch_regs[rt];
        addr_sum = op_a + word_t'(imm);
        word_idx = dmem_idx_t'(addr_sum % DATA_WORDS);
        r        = '0;
        r.next_pc = arch_pc + PC_STEP;
        case (k)
            KIND_ADD:
            begin
                r.reg_write = 1'b1;
                r.reg_index = rd;
                r.reg_value = op_a + op_b;
            end
            KIND_SUB:
            begin
                r.reg_write = 1'b1;
                r.reg_index = rd;
                r.reg_value = op_a - op_b;
            end
            KIND_ADDI:
            begin
                r.reg_write = 1'b1;
                r.reg_index = rt;
                r.reg_value = addr_sum;
            end
            KIND_MUL:
            begin
                r.reg_write = 1'b1;
                r.reg_index = rd;
                r.reg_value = op_a * op_b;
            end
            KIND_LW:
            begin
                r.mem_index = mem_index_t'(word_idx);
                r.reg_write = 1'b1;
                r.reg_index = rt;
                r.reg_value = data_mem[word_idx];
            end
            KIND_SW:
            begin
                r.mem_index = mem_index_t'(word_idx);
                r.mem_write = 1'b1;
                r.mem_value = op_b;
                data_mem[word_idx] = op_b;
            end
            KIND_BEQ:
            begin
                if (op_a == op_b)
                begin
                    r.branch_taken = 1'b1;
                    r.next_pc = arch_pc + PC_STEP + (word_t'(imm) << 2);
                end
            end
            default:
            begin
                r.next_pc = arch_pc;
            end
        endcase
        // r0 is hardwired: writes to it vanish from the result too
        if (r.reg_write && r.reg_index == '0)
        begin
            r.reg_write = 1'b0;
            r.reg_value = '0;
        end
        if (r.reg_write)
            arch_regs[r.reg_index] = r.reg_value;
        else
            r.reg_index = '0;
        arch_pc = r.next_pc;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                arch_regs[i] = '0;
            for (int i = 0; i < DATA_WORDS; i++)
                data_mem[i] = '0;
            arch_pc = '0;
            results_due.delete();
        end
        else
        begin
            if (instr_mon.valid && instr_mon.ready)
                results_due.push_back(execute_instr(instr_mon.kind, instr_mon.src_reg,
                                                    instr_mon.second_reg,
                                                    instr_mon.dest_reg,
                                                    instr_mon.imm_value));
            if (result_mon.valid && result_mon.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result transfer with no instruction outstanding");
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("next_pc", want.next_pc, result_mon.next_pc);
                    check_field("branch_taken", 32'(want.branch_taken),
                                32'(result_mon.branch_taken));
                    check_field("reg_write", 32'(want.reg_write), 32'(result_mon.reg_write));
                    check_field("reg_index", 32'(want.reg_index), 32'(result_mon.reg_index));
                    check_field("reg_value", want.reg_value, result_mon.reg_value);
                    check_field("mem_write", 32'(want.mem_write), 32'(result_mon.mem_write));
                    check_field("mem_index", 32'(want.mem_index), 32'(result_mon.mem_index));
                    check_field("mem_value", want.mem_value, result_mon.mem_value);
                    check_count++;
                end
            end
        end
        failures        <= fail_count;
        outstanding     <= results_due.size();
        results_checked <= check_count;
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the execute block. Prediction and comparison
// live in mse_checker; this module drives the channels and reports the verdict.
module tb_top;
    import mse_pkg::*;

    localparam int RANDOM_PER_PHASE = 217;
    localparam int HOLD_CYCLES      = 300;  // long output stall, fills the pipe
    localparam int MAX_GAP          = 20;   // cap on one run of sender idles
    localparam int DRAIN_CYCLES     = 16;   // generous margin after the final drain
    localparam int LIMIT_CYCLES     = 200000;

    logic clk = 1'b0;
    logic rst_n;

    mse_in_if  instr_bus ();
    mse_out_if result_bus ();

    int failures;
    int outstanding;
    int results_checked;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;   // bumped by stimulus to ask for a long stall
    int hold_seen   = 0;
    int hold_left   = 0;
    int instrs_sent = 0;
    int cycle_count = 0;

    mips_subset_execute i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_bus),
        .result (result_bus)
    );

    mse_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .instr_mon       (instr_bus),
        .result_mon      (result_bus),
        .failures        (failures),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always #4 clk = ~clk;

    // Run limit, far beyond the slowest legal run: the post-reset memory sweep
    // plus all transfers with their stalls.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Result side. A long hold-off is counted here, in cycles, once the
    // stimulus asks for it; otherwise ready drops at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            result_bus.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES - 1;
            result_bus.ready <= 1'b0;
        end
        else
            result_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // One instruction transfer, preceded by a random run of idle cycles.
    // valid stays high between back-to-back transfers, so it is never
    // lowered and raised in the same step.
    task automatic send_instr(input kind_t k, input reg_idx_t rs, input reg_idx_t rt,
                              input reg_idx_t rd, input imm_t imm);
        int gap;
        gap = 0;
        while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct && gap < MAX_GAP)
        begin
            instr_bus.valid <= 1'b0;
            @(posedge clk);
            gap++;
        end
        instr_bus.valid      <= 1'b1;
        instr_bus.kind       <= k;
        instr_bus.src_reg    <= rs;
        instr_bus.second_reg <= rt;
        instr_bus.dest_reg   <= rd;
        instr_bus.imm_value  <= imm;
        @(posedge clk);
        while (!instr_bus.ready)
            @(posedge clk);
        instrs_sent++;
    endtask

    // Random instruction with a bias towards the interesting corners:
    // loads and stores cluster on a few low words so loads hit earlier
    // stores, and beq often compares a register with itself.
    task automatic send_random();
        kind_t       k;
        reg_idx_t    rs;
        reg_idx_t    rt;
        reg_idx_t    rd;
        imm_t        imm;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 14)
            k = KIND_ADD;
        else if (pick < 26)
            k = KIND_SUB;
        else if (pick < 42)
            k = KIND_ADDI;
        else if (pick < 52)
            k = KIND_MUL;
        else if (pick < 66)
            k = KIND_LW;
        else if (pick < 80)
            k = KIND_SW;
        else if (pick < 94)
            k = KIND_BEQ;
        else
            k = KIND_BUBBLE;
        rs = ($urandom_range(0, 3) == 0) ? '0 : reg_idx_t'($urandom_range(0, 31));
        rt = reg_idx_t'($urandom_range(0, 31));
        rd = reg_idx_t'($urandom_range(0, 31));
        case ($urandom_range(0, 3))
            0:       imm = imm_t'($urandom_range(0, 65534));
            1:       imm = imm_t'($urandom_range(0, 31));
            2:       imm = imm_t'($urandom_range(65504, 65534));
            default: imm = imm_t'($urandom_range(0, 2047));
        endcase
        if ((k == KIND_LW || k == KIND_SW) && $urandom_range(0, 99) < 60)
        begin
            rs  = '0;
            imm = imm_t'($urandom_range(0, 31));
        end
        if (k == KIND_BEQ && $urandom_range(0, 99) < 40)
            rt = rs;
        send_instr(k, rs, rt, rd, imm);
    endtask

    // Sender goes quiet until every predicted result has been taken.
    // The first edge lets the checker count the last transfer.
    task automatic wait_drained();
        instr_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        instr_bus.valid      <= 1'b0;
        instr_bus.kind       <= KIND_BUBBLE;
        instr_bus.src_reg    <= '0;
        instr_bus.second_reg <= '0;
        instr_bus.dest_reg   <= '0;
        instr_bus.imm_value  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part; ready is held off by the block through the
        // post-reset memory sweep, the send simply waits for it.
        // r1 = 0xfffe, r2 = 0x1fffc, r3 = r2*r2 (low word), r4 = 0 - r1
        send_instr(KIND_ADDI, 5'd0, 5'd1, 5'd0, 16'd65534);
        send_instr(KIND_ADDI, 5'd1, 5'd2, 5'd0, 16'd65534);
        send_instr(KIND_MUL, 5'd2, 5'd2, 5'd3, 16'd0);
        send_instr(KIND_SUB, 5'd0, 5'd1, 5'd4, 16'd0);
        send_instr(KIND_ADD, 5'd4, 5'd3, 5'd5, 16'd0);
        // writes aimed at r0 are dropped
        send_instr(KIND_ADD, 5'd1, 5'd2, 5'd0, 16'd0);
        send_instr(KIND_ADDI, 5'd1, 5'd0, 5'd0, 16'd12);
        // r4 + 0xfffe wraps past 2^32 to word 0
        send_instr(KIND_SW, 5'd4, 5'd5, 5'd0, 16'd65534);
        send_instr(KIND_LW, 5'd4, 5'd6, 5'd0, 16'd65534);
        // load from a word nobody wrote: cleared at reset
        send_instr(KIND_LW, 5'd0, 5'd7, 5'd0, 16'd1234);
        // top word of memory, then a load into r0 and one into r31
        send_instr(KIND_SW, 5'd0, 5'd3, 5'd0, 16'd2047);
        send_instr(KIND_LW, 5'd0, 5'd0, 5'd0, 16'd2047);
        send_instr(KIND_LW, 5'd0, 5'd31, 5'd0, 16'd2047);
        // index beyond the depth wraps: 0x1fffc + 5 -> word 1
        send_instr(KIND_SW, 5'd2, 5'd4, 5'd0, 16'd5);
        send_instr(KIND_LW, 5'd0, 5'd8, 5'd0, 16'd1);
        // branches: taken far, not taken, taken by zero words
        send_instr(KIND_BEQ, 5'd1, 5'd1, 5'd0, 16'd65534);
        send_instr(KIND_BEQ, 5'd1, 5'd2, 5'd0, 16'd7);
        send_instr(KIND_BEQ, 5'd0, 5'd0, 5'd0, 16'd0);
        // bubble with every other field set: pc must stay put
        send_instr(KIND_BUBBLE, 5'd31, 5'd31, 5'd31, 16'd65534);
        send_instr(KIND_SUB, 5'd4, 5'd5, 5'd9, 16'd0);
        send_instr(KIND_MUL, 5'd4, 5'd4, 5'd10, 16'd0);
        send_instr(KIND_ADD, 5'd31, 5'd1, 5'd31, 16'd0);
        wait_drained();

        // Random part in three handshake mixes: sparse sender idles with a
        // sluggish receiver, the reverse, then full rate. The full-rate
        // mix opens with a long receiver hold-off while the sender keeps
        // offering, so the pipe fills and instr.ready must drop.
        for (int mix = 0; mix < 3; mix++)
        begin
            tx_idle_pct = (mix == 0) ? 9 : (mix == 1) ? 62 : 0;
            rx_idle_pct = (mix == 0) ? 62 : (mix == 1) ? 9 : 0;
            if (mix == 2)
                hold_req++;
            repeat (RANDOM_PER_PHASE) send_random();
            wait_drained();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d instructions: all kinds, r0 and wrap corners, three idle mixes,",
                 instrs_sent);
        $display("a %0d-cycle output hold and full drains; %0d results compared.",
                 HOLD_CYCLES, results_checked);
        if (failures == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== mips_subset_execute.f =====
+incdir+src
src/mse_pkg.sv
src/mse_channels.sv
src/mse_regfile.sv
src/mse_dmem.sv
src/mips_subset_execute.sv
sim/mse_checker.sv
sim/tb_top.sv
